/* rtl/srp_pkg.sv */
package srp_pkg;

    localparam int          DIM      = 7;
    localparam int          W_RES    = 30;
    localparam int          W_IDX    = 3;
    localparam int          W_BANK   = 2;
    localparam int          W_ADDR   = W_BANK + 2 * W_IDX;
    localparam int          W_OPND   = 32;

    localparam logic [W_RES-1:0] P_MOD   = 30'd1000000007;
    localparam logic [63:0]      BAR_NUM = 64'h4000_0000_0000_0000;
    localparam logic [32:0]      BAR_M   = 33'(BAR_NUM / 64'(P_MOD));

    typedef logic [W_RES-1:0]  t_res;
    typedef logic [W_IDX-1:0]  t_idx;
    typedef logic [W_BANK-1:0] t_bank;
    typedef logic [W_ADDR-1:0] t_addr;
    typedef logic [W_OPND-1:0] t_opnd;

    typedef enum logic [1:0] {
        K_RED   = 2'd0,
        K_CROSS = 2'd1,
        K_MAT   = 2'd2,
        K_DOT   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_idx  i;
        t_idx  j;
        logic  first;
        logic  last;
    } t_tag;

    typedef struct packed {
        logic [63:0] step_count;
        logic [31:0] a_start;
        logic [31:0] a_mul;
        logic [31:0] a_add;
        logic [31:0] b_start;
        logic [31:0] b_mul;
        logic [31:0] b_add;
    } t_in_item;

    typedef struct packed {
        logic [29:0] product_sum;
    } t_out_item;

endpackage

/* rtl/srp_if.sv */
interface srp_in_if import srp_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srp_out_if import srp_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/srp_mulmod.sv */
module srp_mulmod import srp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_opnd i_a,
    input  t_opnd i_b,
    input  t_tag  i_tag,
    output logic  o_vld,
    output t_res  o_res,
    output t_tag  o_tag
);

    logic [3:0]  r_vld;
    logic [59:0] r_x1;
    logic [30:0] r_q2;
    logic [31:0] r_xl2;
    logic [31:0] r_qp3;
    logic [31:0] r_xl3;
    t_res        r_res;
    t_tag        r_tag [0:3];

    logic [63:0] w_prod;
    logic [64:0] w_tm;
    logic [60:0] w_qp;
    logic [31:0] w_d;
    logic [31:0] w_dc;

    assign w_prod = i_a * i_b;
    assign w_tm   = r_x1[59:28] * BAR_M;
    assign w_qp   = r_q2 * P_MOD;
    assign w_d    = r_xl3 - r_qp3;
    assign w_dc   = (w_d >= {2'b00, P_MOD}) ? (w_d - {2'b00, P_MOD}) : w_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1     <= w_prod[59:0];
        r_tag[0] <= i_tag;
        r_q2     <= w_tm[64:34];
        r_xl2    <= r_x1[31:0];
        r_tag[1] <= r_tag[0];
        r_qp3    <= w_qp[31:0];
        r_xl3    <= r_xl2;
        r_tag[2] <= r_tag[1];
        r_res    <= w_dc[W_RES-1:0];
        r_tag[3] <= r_tag[2];
    end

    assign o_vld = r_vld[3];
    assign o_res = r_res;
    assign o_tag = r_tag[3];

endmodule

/* rtl/srp_mat_mem.sv */
module srp_mat_mem import srp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_res  i_wdata,
    input  t_addr i_raddr_a,
    input  t_addr i_raddr_b,
    output t_res  o_rdata_a,
    output t_res  o_rdata_b
);

    t_res r_mem [0:(1 << W_ADDR)-1];
    t_res r_rd_a;
    t_res r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

/* rtl/sum_of_recurrence_products_mod.sv */
// Sum of a_i*b_i for i = 0..n-1 modulo 1e9+7, for two affine recurrences given by
// start, multiplier and addend. The block raises a 7x7 transition matrix to the power n
// by square-and-multiply and dots row 3 with the start vector. All products go through
// one pipelined Barrett modular multiplier that takes one 32x32 product per cycle, fed
// from a two-read, one-write matrix memory holding three 7x7 matrices. Each matrix
// product issues 343 multiplications, then waits for the multiplier pipeline to drain
// and takes a sequencing step, so an item needs popcount(n) + floor(log2(n)) matrix
// products, none for n = 0. The input is ready only while the block is idle;
// a finished result waits in the output register, and a new item is accepted meanwhile.
module sum_of_recurrence_products_mod import srp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    srp_in_if.sink    i_in,
    srp_out_if.source o_out
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_RED     = 12'b0000_0000_0010,
        S_RED_W   = 12'b0000_0000_0100,
        S_CROSS   = 12'b0000_0000_1000,
        S_CROSS_W = 12'b0000_0001_0000,
        S_INIT    = 12'b0000_0010_0000,
        S_NEXT    = 12'b0000_0100_0000,
        S_MAT     = 12'b0000_1000_0000,
        S_MAT_W   = 12'b0001_0000_0000,
        S_DOT     = 12'b0010_0000_0000,
        S_DOT_W   = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    localparam int   N_CF     = 6;
    localparam int   N_XP     = 5;
    localparam t_idx LAST     = t_idx'(DIM - 1);
    localparam t_idx CF_LAST  = t_idx'(N_CF - 1);
    localparam t_idx XP_LAST  = t_idx'(N_XP - 1);
    localparam t_idx SUM_ROW  = t_idx'(3);
    localparam int   CF_A0    = 0;
    localparam int   CF_AX    = 1;
    localparam int   CF_AY    = 2;
    localparam int   CF_B0    = 3;
    localparam int   CF_BX    = 4;
    localparam int   CF_BY    = 5;
    localparam int   XP_AXBY  = 0;
    localparam int   XP_BXAY  = 1;
    localparam int   XP_AXBX  = 2;
    localparam int   XP_A0B0  = 3;
    localparam int   XP_AYBY  = 4;
    localparam t_res ONE      = t_res'(1);

    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic [63:0] r_n, n_n;
    t_idx        r_i, n_i;
    t_idx        r_j, n_j;
    t_idx        r_k, n_k;
    logic        r_which, n_which;
    logic        r_sq, n_sq;
    logic        r_mul_done, n_mul_done;
    t_bank       r_acc_bk, n_acc_bk;
    t_bank       r_base_bk, n_base_bk;
    t_bank       r_free_bk, n_free_bk;
    t_res        r_acc, n_acc;
    logic        r_rd_vld, n_rd_vld;
    t_tag        r_rd_tag, n_rd_tag;
    logic        r_out_vld, n_out_vld;
    t_res        r_out, n_out;
    t_res        r_cf [0:N_CF-1];
    t_res        r_xp [0:N_XP-1];

    logic  prep_vld;
    t_opnd prep_a;
    t_opnd prep_b;
    t_tag  prep_tag;
    t_tag  rd_tag;
    t_addr raddr_a;
    t_addr raddr_b;
    t_res  rdata_a;
    t_res  rdata_b;
    t_res  vec_val;
    t_res  init_val;
    logic  mem_we;
    t_addr mem_waddr;
    t_res  mem_wdata;
    logic  u_in_vld;
    t_opnd u_in_a;
    t_opnd u_in_b;
    t_tag  u_in_tag;
    logic  u_vld;
    t_res  u_res;
    t_tag  u_tag;
    t_res  sum_in;
    logic [W_RES:0] sum_raw;
    logic [W_RES:0] sum_red;
    t_res  sum_mod;
    logic  ret_acc;
    logic  mat_final;
    logic  in_acc;

    srp_mat_mem u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    srp_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (u_in_vld),
        .i_a     (u_in_a),
        .i_b     (u_in_b),
        .i_tag   (u_in_tag),
        .o_vld   (u_vld),
        .o_res   (u_res),
        .o_tag   (u_tag)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign o_out.valid            = r_out_vld;
    assign o_out.data.product_sum = r_out;

    always_comb begin
        prep_vld = (r_state == S_RED) || (r_state == S_CROSS);
        prep_a   = '0;
        prep_b   = '0;
        prep_tag = '{kind: K_RED, i: '0, j: r_k, first: (r_k == '0), last: 1'b0};
        if (r_state == S_RED) begin
            prep_b        = t_opnd'(1);
            prep_tag.last = (r_k == CF_LAST);
            case (r_k)
                3'd0:    prep_a = r_item.a_start;
                3'd1:    prep_a = r_item.a_mul;
                3'd2:    prep_a = r_item.a_add;
                3'd3:    prep_a = r_item.b_start;
                3'd4:    prep_a = r_item.b_mul;
                default: prep_a = r_item.b_add;
            endcase
        end else begin
            prep_tag.kind = K_CROSS;
            prep_tag.last = (r_k == XP_LAST);
            case (r_k)
                3'd0: begin
                    prep_a = t_opnd'(r_cf[CF_AX]);
                    prep_b = t_opnd'(r_cf[CF_BY]);
                end
                3'd1: begin
                    prep_a = t_opnd'(r_cf[CF_BX]);
                    prep_b = t_opnd'(r_cf[CF_AY]);
                end
                3'd2: begin
                    prep_a = t_opnd'(r_cf[CF_AX]);
                    prep_b = t_opnd'(r_cf[CF_BX]);
                end
                3'd3: begin
                    prep_a = t_opnd'(r_cf[CF_A0]);
                    prep_b = t_opnd'(r_cf[CF_B0]);
                end
                default: begin
                    prep_a = t_opnd'(r_cf[CF_AY]);
                    prep_b = t_opnd'(r_cf[CF_BY]);
                end
            endcase
        end
    end

    always_comb begin
        if (r_state == S_DOT) begin
            rd_tag  = '{kind: K_DOT, i: SUM_ROW, j: r_k, first: (r_k == '0),
                        last: (r_k == LAST)};
            raddr_a = {r_acc_bk, SUM_ROW, r_k};
        end else begin
            rd_tag  = '{kind: K_MAT, i: r_i, j: r_j, first: (r_k == '0),
                        last: (r_k == LAST)};
            raddr_a = {(r_sq ? r_base_bk : r_acc_bk), r_i, r_k};
        end
        raddr_b = {r_base_bk, r_k, r_j};
    end

    always_comb begin
        case (r_rd_tag.j)
            3'd0:    vec_val = r_cf[CF_A0];
            3'd1:    vec_val = r_cf[CF_B0];
            3'd2:    vec_val = r_xp[XP_A0B0];
            3'd3:    vec_val = '0;
            3'd4:    vec_val = r_cf[CF_AY];
            3'd5:    vec_val = r_cf[CF_BY];
            default: vec_val = r_xp[XP_AYBY];
        endcase
    end

    always_comb begin
        u_in_vld = r_rd_vld || prep_vld;
        if (r_rd_vld) begin
            u_in_a   = t_opnd'(rdata_a);
            u_in_b   = (r_rd_tag.kind == K_DOT) ? t_opnd'(vec_val) : t_opnd'(rdata_b);
            u_in_tag = r_rd_tag;
        end else begin
            u_in_a   = prep_a;
            u_in_b   = prep_b;
            u_in_tag = prep_tag;
        end
    end

    always_comb begin
        init_val = '0;
        if (!r_which) begin
            init_val = (r_i == r_j) ? ONE : '0;
        end else begin
            case ({r_i, r_j})
                {3'd0, 3'd0}: init_val = r_cf[CF_AX];
                {3'd0, 3'd4}: init_val = ONE;
                {3'd1, 3'd1}: init_val = r_cf[CF_BX];
                {3'd1, 3'd5}: init_val = ONE;
                {3'd2, 3'd0}: init_val = r_xp[XP_AXBY];
                {3'd2, 3'd1}: init_val = r_xp[XP_BXAY];
                {3'd2, 3'd2}: init_val = r_xp[XP_AXBX];
                {3'd2, 3'd6}: init_val = ONE;
                {3'd3, 3'd2}: init_val = ONE;
                {3'd3, 3'd3}: init_val = ONE;
                {3'd4, 3'd4}: init_val = ONE;
                {3'd5, 3'd5}: init_val = ONE;
                {3'd6, 3'd6}: init_val = ONE;
                default:      init_val = '0;
            endcase
        end
    end

    assign sum_in  = u_tag.first ? '0 : r_acc;
    assign sum_raw = {1'b0, sum_in} + {1'b0, u_res};
    assign sum_red = sum_raw - {1'b0, P_MOD};
    assign sum_mod = (sum_raw >= {1'b0, P_MOD}) ? sum_red[W_RES-1:0] : sum_raw[W_RES-1:0];
    assign ret_acc = u_vld && ((u_tag.kind == K_MAT) || (u_tag.kind == K_DOT));
    assign mat_final = u_vld && (u_tag.kind == K_MAT) && u_tag.last
                       && (u_tag.i == LAST) && (u_tag.j == LAST);

    always_comb begin
        if (r_state == S_INIT) begin
            mem_we    = 1'b1;
            mem_waddr = {(r_which ? r_base_bk : r_acc_bk), r_i, r_j};
            mem_wdata = init_val;
        end else begin
            mem_we    = u_vld && (u_tag.kind == K_MAT) && u_tag.last;
            mem_waddr = {r_free_bk, u_tag.i, u_tag.j};
            mem_wdata = sum_mod;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_n        = r_n;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_which    = r_which;
        n_sq       = r_sq;
        n_mul_done = r_mul_done;
        n_acc_bk   = r_acc_bk;
        n_base_bk  = r_base_bk;
        n_free_bk  = r_free_bk;
        n_acc      = ret_acc ? sum_mod : r_acc;
        n_rd_vld   = (r_state == S_MAT) || (r_state == S_DOT);
        n_rd_tag   = rd_tag;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !o_out.ready;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item     = i_in.data;
                    n_n        = i_in.data.step_count;
                    n_k        = '0;
                    n_mul_done = 1'b0;
                    n_acc_bk   = t_bank'(0);
                    n_base_bk  = t_bank'(1);
                    n_free_bk  = t_bank'(2);
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                n_k = r_k + t_idx'(1);
                if (r_k == CF_LAST) begin
                    n_k     = '0;
                    n_state = S_RED_W;
                end
            end
            S_RED_W: begin
                if (u_vld && u_tag.last) begin
                    n_state = S_CROSS;
                end
            end
            S_CROSS: begin
                n_k = r_k + t_idx'(1);
                if (r_k == XP_LAST) begin
                    n_k     = '0;
                    n_state = S_CROSS_W;
                end
            end
            S_CROSS_W: begin
                if (u_vld && u_tag.last) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_which = 1'b0;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_j = r_j + t_idx'(1);
                if (r_j == LAST) begin
                    n_j = '0;
                    n_i = r_i + t_idx'(1);
                    if (r_i == LAST) begin
                        n_i     = '0;
                        n_which = 1'b1;
                        if (r_which) begin
                            n_state = S_NEXT;
                        end
                    end
                end
            end
            S_NEXT: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                if (r_n == '0) begin
                    n_state = S_DOT;
                end else if (r_n[0] && !r_mul_done) begin
                    n_sq    = 1'b0;
                    n_state = S_MAT;
                end else if (r_n[63:1] == '0) begin
                    n_state = S_DOT;
                end else begin
                    n_sq    = 1'b1;
                    n_state = S_MAT;
                end
            end
            S_MAT: begin
                n_k = r_k + t_idx'(1);
                if (r_k == LAST) begin
                    n_k = '0;
                    n_j = r_j + t_idx'(1);
                    if (r_j == LAST) begin
                        n_j = '0;
                        n_i = r_i + t_idx'(1);
                        if (r_i == LAST) begin
                            n_i     = '0;
                            n_state = S_MAT_W;
                        end
                    end
                end
            end
            S_MAT_W: begin
                if (mat_final) begin
                    n_free_bk = r_sq ? r_base_bk : r_acc_bk;
                    if (r_sq) begin
                        n_base_bk  = r_free_bk;
                        n_n        = {1'b0, r_n[63:1]};
                        n_mul_done = 1'b0;
                    end else begin
                        n_acc_bk   = r_free_bk;
                        n_mul_done = 1'b1;
                    end
                    n_state = S_NEXT;
                end
            end
            S_DOT: begin
                n_k = r_k + t_idx'(1);
                if (r_k == LAST) begin
                    n_k     = '0;
                    n_state = S_DOT_W;
                end
            end
            S_DOT_W: begin
                if (u_vld && u_tag.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out     = r_acc;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_which    <= 1'b0;
            r_sq       <= 1'b0;
            r_mul_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_which    <= n_which;
            r_sq       <= n_sq;
            r_mul_done <= n_mul_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_n       <= n_n;
        r_acc_bk  <= n_acc_bk;
        r_base_bk <= n_base_bk;
        r_free_bk <= n_free_bk;
        r_acc     <= n_acc;
        r_rd_tag  <= n_rd_tag;
        r_out     <= n_out;
        if (u_vld && (u_tag.kind == K_RED)) begin
            r_cf[u_tag.j] <= u_res;
        end
        if (u_vld && (u_tag.kind == K_CROSS)) begin
            r_xp[u_tag.j] <= u_res;
        end
    end

endmodule

/* rtl/srp_checker.sv */
module srp_checker import srp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_res i_product_sum
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_product_sum))
        else $error("result changed or dropped while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_product_sum < P_MOD))
        else $error("result not reduced below modulus");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after an accepted item");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sum_of_recurrence_products_mod srp_checker u_srp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_product_sum (o_out.data.product_sum)
);

/* sim/tb_sum_of_recurrence_products_mod.sv */
module tb_sum_of_recurrence_products_mod;
    import srp_pkg::*;

    localparam longint unsigned PRIME       = 64'd1000000007;
    localparam int              N_DIR       = 16;
    localparam int              N_RAND      = 100;
    localparam int              HOLD_CYCLES = 50000;
    localparam int              TAIL_CYCLES = 500;
    localparam longint          LIMIT       = 64'd25000000;

    typedef struct packed {
        logic [63:0] steps;
        logic [31:0] a_s;
        logic [31:0] a_m;
        logic [31:0] a_a;
        logic [31:0] b_s;
        logic [31:0] b_m;
        logic [31:0] b_a;
        logic        known;
        t_res        want;
    } t_row;

    localparam t_row DIR_ROWS [N_DIR] = '{
        '{64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 30'd0},
        '{64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 30'd0},
        '{64'd1, 32'd3, 32'd0, 32'd0, 32'd5, 32'd0, 32'd0, 1'b1, 30'd15},
        '{64'd1, 32'd1000000007, 32'd9, 32'd9, 32'd7, 32'd9, 32'd9, 1'b1, 30'd0},
        '{64'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 1'b1, 30'd294967267},
        '{64'd1, 32'd1000000006, 32'd5, 32'd5, 32'd1000000006, 32'd5, 32'd5,
          1'b1, 30'd1},
        '{64'd2, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 1'b1, 30'd5},
        '{64'd1, 32'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 1'b1, 30'd42},
        '{64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b1, 30'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 30'd0},
        '{64'h8000_0000_0000_0000, 32'd123456789, 32'd987654321, 32'd1000000008,
          32'd42, 32'hFFFF_FFFE, 32'd1000000006, 1'b0, 30'd0},
        '{64'd3, 32'd2, 32'd1000000006, 32'd1000000008, 32'd3, 32'd1000000007,
          32'd4, 1'b0, 30'd0},
        '{64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
          32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 1'b0, 30'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
          32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 30'd0},
        '{64'd100, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 1'b0, 30'd0},
        '{64'd1000000007, 32'd7, 32'd11, 32'd13, 32'd17, 32'd19, 32'd23, 1'b0, 30'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    srp_in_if  in_if ();
    srp_out_if out_if ();

    sum_of_recurrence_products_mod u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    t_res   pending_sums [$];
    int     mismatches   = 0;
    int     results_seen = 0;
    longint cycles       = 0;
    bit     send_idle    = 1'b1;
    bit     recv_idle    = 1'b1;

    function automatic longint unsigned mod_mul(longint unsigned x, longint unsigned y);
        return (x % PRIME) * (y % PRIME) % PRIME;
    endfunction

    function automatic void mat_mul(input longint unsigned x [DIM][DIM],
                                    input longint unsigned y [DIM][DIM],
                                    output longint unsigned r [DIM][DIM]);
        longint unsigned acc;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                acc = 0;
                for (int k = 0; k < DIM; k++) begin
                    acc = (acc + mod_mul(x[i][k], y[k][j])) % PRIME;
                end
                r[i][j] = acc;
            end
        end
    endfunction

    function automatic t_res recurrence_product_sum(t_in_item it);
        longint unsigned a0, ax, ay, b0, bx, by, sum;
        longint unsigned step [DIM][DIM];
        longint unsigned pw [DIM][DIM];
        longint unsigned tmp [DIM][DIM];
        longint unsigned vec [DIM];
        logic [63:0]     n;
        n  = it.step_count;
        a0 = longint'(it.a_start) % PRIME;
        ax = longint'(it.a_mul) % PRIME;
        ay = longint'(it.a_add) % PRIME;
        b0 = longint'(it.b_start) % PRIME;
        bx = longint'(it.b_mul) % PRIME;
        by = longint'(it.b_add) % PRIME;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                step[i][j] = 0;
                pw[i][j]   = (i == j) ? 1 : 0;
            end
        end
        step[0][0] = ax;
        step[0][4] = 1;
        step[1][1] = bx;
        step[1][5] = 1;
        step[2][0] = mod_mul(ax, by);
        step[2][1] = mod_mul(bx, ay);
        step[2][2] = mod_mul(ax, bx);
        step[2][6] = 1;
        step[3][2] = 1;
        step[3][3] = 1;
        step[4][4] = 1;
        step[5][5] = 1;
        step[6][6] = 1;
        while (n != 0) begin
            if (n[0]) begin
                mat_mul(pw, step, tmp);
                pw = tmp;
            end
            n = n >> 1;
            mat_mul(step, step, tmp);
            step = tmp;
        end
        vec[0] = a0;
        vec[1] = b0;
        vec[2] = mod_mul(a0, b0);
        vec[3] = 0;
        vec[4] = ay;
        vec[5] = by;
        vec[6] = mod_mul(ay, by);
        sum = 0;
        for (int i = 0; i < DIM; i++) begin
            sum = (sum + mod_mul(pw[3][i], vec[i])) % PRIME;
        end
        return t_res'(sum);
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 32'(PRIME) - 32'd1 + 32'($urandom_range(0, 2));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            2: return 32'($urandom_range(0, 10));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_steps();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return 64'($urandom_range(0, 300));
        end else if (r < 95) begin
            return 64'($urandom_range(0, 32'hF_FFFF));
        end
        return {$urandom, $urandom};
    endfunction

    task automatic report(string what, t_res want, t_res got);
        if (mismatches < 10) begin
            $display("%s: expected %0d, got %0d", what, want, got);
        end
        mismatches++;
    endtask

    task automatic offer(input t_in_item it, input t_res want);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        pending_sums.push_back(want);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_sum_of_recurrence_products_mod: errors");
            $finish;
        end
    end

    initial begin
        int unsigned gap;
        out_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (results_seen % 12 == 0) begin
                recv_idle = $urandom_range(0, 3) != 0;
            end
            if (results_seen == N_DIR + 4) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = recv_idle ? $urandom_range(0, 10) : 0;
                if (gap != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            results_seen++;
            if (pending_sums.size() == 0) begin
                report("unexpected result", '0, out_if.data.product_sum);
            end else begin
                t_res want;
                want = pending_sums.pop_front();
                if (out_if.data.product_sum !== want) begin
                    report("product_sum mismatch", want, out_if.data.product_sum);
                end
            end
        end
    end

    initial begin
        t_in_item it;
        t_res     want;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < N_DIR; r++) begin
            it.step_count = DIR_ROWS[r].steps;
            it.a_start    = DIR_ROWS[r].a_s;
            it.a_mul      = DIR_ROWS[r].a_m;
            it.a_add      = DIR_ROWS[r].a_a;
            it.b_start    = DIR_ROWS[r].b_s;
            it.b_mul      = DIR_ROWS[r].b_m;
            it.b_add      = DIR_ROWS[r].b_a;
            want = DIR_ROWS[r].known ? DIR_ROWS[r].want : recurrence_product_sum(it);
            offer(it, want);
        end
        for (int r = 0; r < N_RAND; r++) begin
            if (r % 12 == 0) begin
                send_idle = $urandom_range(0, 3) != 0;
            end
            it.step_count = pick_steps();
            it.a_start    = pick_coef();
            it.a_mul      = pick_coef();
            it.a_add      = pick_coef();
            it.b_start    = pick_coef();
            it.b_mul      = pick_coef();
            it.b_add      = pick_coef();
            offer(it, recurrence_product_sum(it));
        end
        in_if.valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_sum_of_recurrence_products_mod: clean");
        end else begin
            $display("tb_sum_of_recurrence_products_mod: errors");
        end
        $finish;
    end

endmodule
